@@ src/bh64_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bh64_pkg
// Shared types, constants and helpers for the 64-bit streaming byte hash.
// ----------------------------------------------------------------------------
package bh64_pkg;

  // hash multiplier, split into 32-bit halves for the iterative multiplier
  localparam logic [63:0] HASH_MUL   = 64'hc6a4a793_5bd1e995;
  localparam logic [31:0] MUL_HI     = HASH_MUL[63:32];
  localparam logic [31:0] MUL_LO     = HASH_MUL[31:0];
  localparam int unsigned SHIFT_AMT  = 47;
  localparam logic [63:0] SEED_RESET = 64'h0000_0000_00c7_0697;

  // partial products per 64-bit modular multiply
  localparam int unsigned MUL_STEPS  = 3;

  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NBYTES_W   = 4;
  localparam int unsigned LEN_W      = 32;
  localparam logic [NBYTES_W-1:0] FULL_BYTES = 4'd8;

  // how the back end folds a word
  typedef enum logic [1:0] {
    K_NONE = 2'd0,
    K_PART = 2'd1,
    K_FULL = 2'd2
  } word_kind_t;

  // one classified word in the queue
  typedef struct packed {
    logic [WORD_W-1:0] word;
    word_kind_t        kind;
    logic              first;
    logic              last;
    logic [LEN_W-1:0]  len;
  } item_t;

  // multiplier request and response
  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] x;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] res;
  } mul_rsp_t;

  function automatic logic [63:0] xorshift_mix(input logic [63:0] v);
    return v ^ (v >> SHIFT_AMT);
  endfunction

endpackage

@@ src/bh64_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bh64_front
// Accepts input beats, drops words outside a message, masks partial words
// and classifies each word for the back end.
// ----------------------------------------------------------------------------
module bh64_front
  import bh64_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [WORD_W-1:0]   word_data,
  input  logic [NBYTES_W-1:0] valid_bytes,
  input  logic                first_word,
  input  logic                last_word,
  input  logic [LEN_W-1:0]    message_length,
  output logic                push_valid,
  input  logic                push_ready,
  output item_t               push_item
);

  logic                in_msg_r;
  logic                in_msg_nxt;
  logic                accept;
  logic                keep;
  logic [NBYTES_W-1:0] nbytes;
  logic [WORD_W-1:0]   masked;

  assign in_ready = push_ready;
  assign accept   = in_valid & push_ready;
  assign keep     = first_word | in_msg_r;

  // clamp byte count to a full word
  assign nbytes = (valid_bytes > FULL_BYTES) ? FULL_BYTES : valid_bytes;

  // keep only the valid low bytes
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[i*8 +: 8] = (NBYTES_W'(i) < nbytes) ? word_data[i*8 +: 8] : 8'h00;
    end
  end

  // classify and build the queue entry
  always_comb begin
    push_item.word  = masked;
    push_item.first = first_word;
    push_item.last  = last_word;
    push_item.len   = message_length;
    if (nbytes == FULL_BYTES) begin
      push_item.kind = K_FULL;
    end else if (nbytes != '0) begin
      push_item.kind = K_PART;
    end else begin
      push_item.kind = K_NONE;
    end
  end

  assign push_valid = in_valid & keep;

  // open message tracking
  always_comb begin
    in_msg_nxt = in_msg_r;
    if (accept && keep) begin
      in_msg_nxt = ~last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
    end else begin
      in_msg_r <= in_msg_nxt;
    end
  end

endmodule

@@ src/bh64_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bh64_queue
// Short first-in first-out queue of classified words between front and back.
// ----------------------------------------------------------------------------
module bh64_queue
  import bh64_pkg::*;
#(
  parameter int unsigned DEPTH = 4
)(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ src/bh64_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bh64_mul
// Iterative 64-bit multiply by the hash constant, modulo 2^64, using one
// 32x32 multiplier for every partial product.
// ----------------------------------------------------------------------------
module bh64_mul
  import bh64_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [1:0] LAST_STEP = 2'(MUL_STEPS - 1);

  logic [63:0] x_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [1:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] prod;

  // pick the partial product for this step
  always_comb begin
    case (cnt_r)
      2'd0: begin
        op_a = x_r[31:0];
        op_b = MUL_LO;
      end
      2'd1: begin
        op_a = x_r[63:32];
        op_b = MUL_LO;
      end
      default: begin
        op_a = x_r[31:0];
        op_b = MUL_HI;
      end
    endcase
  end

  assign prod    = 64'(op_a) * 64'(op_b);
  assign acc_nxt = (cnt_r == 2'd0) ? prod : acc_r + {prod[31:0], 32'h0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  // operand and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r <= req.x;
    end
    if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = acc_r;

endmodule

@@ src/bh64_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bh64_back
// Sequencer that folds each queued word into the running hash, finalizes
// the digest and holds it in the output register.
// ----------------------------------------------------------------------------
module bh64_back
  import bh64_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr,
  input  logic [63:0]       cfg_seed,
  input  logic              q_valid,
  output logic              q_ready,
  input  item_t             q_item,
  output mul_req_t          mul_req,
  input  mul_rsp_t          mul_rsp,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] out_digest
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEN,
    S_WORD,
    S_PRE1,
    S_PRE2,
    S_FOLD,
    S_LAST,
    S_FIN,
    S_EMIT
  } state_t;

  state_t      state_r;
  state_t      state_nxt;
  item_t       cur_r;
  item_t       cur_nxt;
  logic [63:0] hash_r;
  logic [63:0] hash_nxt;
  logic [63:0] seed_r;
  logic [63:0] seed_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [63:0] out_data_r;
  logic [63:0] out_data_nxt;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    hash_nxt      = hash_r;
    seed_nxt      = cfg_wr ? cfg_seed : seed_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    q_ready       = 1'b0;
    mul_req.start = 1'b0;
    mul_req.x     = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          cur_nxt = q_item;
          if (q_item.first) begin
            mul_req.start = 1'b1;
            mul_req.x     = 64'(q_item.len);
            state_nxt     = S_LEN;
          end else begin
            state_nxt = S_WORD;
          end
        end
      end
      // seed mixed with length times multiplier
      S_LEN: begin
        if (mul_rsp.done) begin
          hash_nxt  = seed_r ^ mul_rsp.res;
          state_nxt = S_WORD;
        end
      end
      S_WORD: begin
        case (cur_r.kind)
          K_FULL: begin
            mul_req.start = 1'b1;
            mul_req.x     = cur_r.word;
            state_nxt     = S_PRE1;
          end
          K_PART: begin
            mul_req.start = 1'b1;
            mul_req.x     = hash_r ^ cur_r.word;
            state_nxt     = S_FOLD;
          end
          default: begin
            state_nxt = S_LAST;
          end
        endcase
      end
      // premix of a full word
      S_PRE1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.x     = xorshift_mix(mul_rsp.res);
          state_nxt     = S_PRE2;
        end
      end
      S_PRE2: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.x     = hash_r ^ mul_rsp.res;
          state_nxt     = S_FOLD;
        end
      end
      S_FOLD: begin
        if (mul_rsp.done) begin
          hash_nxt  = mul_rsp.res;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (cur_r.last) begin
          mul_req.start = 1'b1;
          mul_req.x     = xorshift_mix(hash_r);
          state_nxt     = S_FIN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (mul_rsp.done) begin
          hash_nxt  = mul_rsp.res;
          state_nxt = S_EMIT;
        end
      end
      // wait for a free output register
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = xorshift_mix(hash_r);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hash_r      <= '0;
      seed_r      <= SEED_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      seed_r      <= seed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_digest = out_data_r;

endmodule

@@ src/byte_hash_64.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_hash_64
// Streaming 64-bit Murmur-style byte hash with a seed register.
// ----------------------------------------------------------------------------
// Usage:
//   in_* carries message words: word, valid byte count and total length in
//   in_tdata, first-word flag in in_tuser, last-word flag in in_tlast.
//   Words outside an open message are dropped. Each last word yields one
//   digest beat on out_*. cfg_* writes the seed; write it only while idle.
// Work (one shared 32x32 multiplier): a full word is multiplied, mixed,
//   multiplied, folded and multiplied again; a partial word is folded and
//   multiplied; a first word adds the length mix, a last word adds the
//   finalization. A queue of QDEPTH words lets the input run ahead of the hash engine.
// Reset: seed returns to its default, no message is open, queue and output
//   are empty.
// Stall: a held digest blocks the next digest only; words keep entering
//   until the queue fills, then in_tready drops.
// ----------------------------------------------------------------------------
module byte_hash_64
  import bh64_pkg::*;
#(
  parameter int unsigned QDEPTH = 4
)(
  input  logic         clk,
  input  logic         rst_n,
  // config write
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data,    // seed
  // input words
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,    // word_data[63:0], valid_bytes[67:64],
                                    // message_length[99:68], zero pad
  input  logic         in_tuser,    // first_word
  input  logic         in_tlast,    // last_word
  // digest out
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata    // digest[63:0]
);

  logic     push_valid;
  logic     push_ready;
  item_t    push_item;
  logic     pop_valid;
  logic     pop_ready;
  item_t    pop_item;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  assign cfg_ready = 1'b1;

  // classify incoming beats
  bh64_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .word_data      (in_tdata[63:0]),
    .valid_bytes    (in_tdata[67:64]),
    .first_word     (in_tuser),
    .last_word      (in_tlast),
    .message_length (in_tdata[99:68]),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_item      (push_item)
  );

  // decoupling queue
  bh64_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // shared multiplier
  bh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  // hash engine
  bh64_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_valid),
    .cfg_seed   (cfg_data),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_item     (pop_item),
    .mul_req    (mul_req),
    .mul_rsp    (mul_rsp),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_digest (out_tdata)
  );

endmodule

@@ verif/byte_hash_64_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_hash_64_test
// Self-checking bench for the streaming 64-bit byte hash. A queue of message
// words feeds a randomly idling driver; every accepted word updates a local
// copy of the hash state, and each closing word leaves an expected digest
// that the monitor compares with the next digest beat. The first phase uses
// the reset seed; later phases rewrite it (zero, all ones, random) while the block idles.
// ----------------------------------------------------------------------------
module byte_hash_64_test;
  import bh64_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 150;   // lets the queue and engine drain
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_AT      = 40;    // digest count that starts the long stall
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_WORDS  = 560;

  // one message word as the driver sees it
  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        first;
    logic        last;
    logic [31:0] len;
  } word_beat_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [63:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;    // word_data, valid_bytes, message_length, pad
  logic         in_tuser = 1'b0;  // first_word
  logic         in_tlast = 1'b0;  // last_word
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;        // digest

  word_beat_t   pending_words[$];
  logic [63:0]  digests_due[$];
  word_beat_t   cur_beat;
  int unsigned  words_queued = 0;
  int unsigned  send_idle_pct = 16;
  int unsigned  sink_idle_pct = 62;
  int unsigned  fail_count = 0;
  int unsigned  digests_seen = 0;
  int unsigned  stall_left = 0;
  int unsigned  quiet_cycles = 0;
  logic [63:0]  expected_digest;

  // local copy of the hash state
  logic [63:0]  seed_reg = SEED_RESET;
  logic [63:0]  hash_acc = '0;
  logic         msg_open = 1'b0;

  byte_hash_64 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [63:0] xorshift47(input logic [63:0] v);
    return v ^ (v >> 47);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // fold one accepted word into the hash, queue a digest on the closing word
  task automatic absorb_word(input word_beat_t b);
    logic [63:0] h;
    logic [63:0] mask;
    int unsigned n;
    if (b.first) begin
      hash_acc = seed_reg ^ ({32'b0, b.len} * HASH_MUL);
      msg_open = 1'b1;
    end
    if (msg_open) begin
      n = 32'((b.nbytes > FULL_BYTES) ? FULL_BYTES : b.nbytes);
      h = hash_acc;
      if (n == 32'(FULL_BYTES)) begin
        h = (h ^ (xorshift47(b.word * HASH_MUL) * HASH_MUL)) * HASH_MUL;
      end else if (n != 0) begin
        mask = (64'd1 << (8 * n)) - 64'd1;
        h = (h ^ (b.word & mask)) * HASH_MUL;
      end
      hash_acc = h;
      if (b.last) begin
        digests_due.push_back(xorshift47(xorshift47(h) * HASH_MUL));
        msg_open = 1'b0;
      end
    end
  endtask

  task automatic push_word(input logic [63:0] word, input logic [3:0] nbytes,
                           input logic first, input logic last,
                           input logic [31:0] len);
    word_beat_t b;
    b.word = word;
    b.nbytes = nbytes;
    b.first = first;
    b.last = last;
    b.len = len;
    pending_words.push_back(b);
    words_queued++;
  endtask

  // a message of total_bytes split into words; close=0 leaves it open
  task automatic push_message(input int unsigned total_bytes, input logic [31:0] stated,
                              input logic close);
    int unsigned left;
    int unsigned take;
    logic        is_first;
    left = total_bytes;
    is_first = 1'b1;
    do begin
      take = (left > 8) ? 8 : left;
      left -= take;
      push_word(rand64(), take[3:0], is_first, close && (left == 0),
                is_first ? stated : $urandom);
      is_first = 1'b0;
    end while (left != 0);
  endtask

  // first word, then words of any valid byte count, including 9 to 15
  task automatic push_odd_message();
    int unsigned extra;
    extra = $urandom_range(4);
    push_word(rand64(), 4'($urandom_range(15)), 1'b1, extra == 0, $urandom);
    for (int unsigned i = 1; i <= extra; i++)
      push_word(rand64(), 4'($urandom_range(15)), 1'b0, i == extra, $urandom);
  endtask

  task automatic queue_random_words(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned nbytes_total;
    stop_at = words_queued + count;
    while (words_queued < stop_at) begin
      pick = $urandom_range(99);
      // mostly short messages, a few long ones
      if ($urandom_range(19) == 0)      nbytes_total = $urandom_range(255, 65);
      else if ($urandom_range(3) == 0)  nbytes_total = $urandom_range(64, 25);
      else                              nbytes_total = $urandom_range(24);
      if (pick < 75) begin
        push_message(nbytes_total,
                     ($urandom_range(9) == 0) ? $urandom : nbytes_total, 1'b1);
      end else if (pick < 85) begin
        // broken message: never closed, the next first word restarts
        push_message(nbytes_total, nbytes_total, 1'b0);
      end else if (pick < 93) begin
        push_odd_message();
      end else begin
        push_word(rand64(), 4'($urandom_range(15)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), $urandom);
      end
    end
  endtask

  // sender holds until all digests are back and the engine has drained
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || digests_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    seed_reg = value;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // driver: next word from the queue, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) absorb_word(cur_beat);
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat = pending_words.pop_front();
          in_tdata  <= {4'b0, cur_beat.len, cur_beat.nbytes, cur_beat.word};
          in_tuser  <= cur_beat.first;
          in_tlast  <= cur_beat.last;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each digest beat, random backpressure plus one long stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (digests_due.size() == 0) begin
          $display("%0t: digest %h with none expected", $time, out_tdata);
          fail_count++;
        end else begin
          expected_digest = digests_due.pop_front();
          if (out_tdata !== expected_digest) begin
            $display("%0t: digest mismatch, expected %h, actual %h",
                     $time, expected_digest, out_tdata);
            fail_count++;
          end
        end
        digests_seen++;
        if (digests_seen == HOLD_AT) stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("byte_hash_64 test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // stimulus and phases
  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed words under the reset seed
    push_word(rand64(), 4'd0, 1'b1, 1'b1, 32'd0);            // empty message
    push_word('1, 4'd8, 1'b1, 1'b1, 32'd8);
    push_word('0, 4'd8, 1'b1, 1'b1, 32'hFFFF_FFFF);
    push_word('1, 4'd1, 1'b1, 1'b1, 32'd1);
    push_word('1, 4'd7, 1'b1, 1'b1, 32'd7);
    push_word('1, 4'd15, 1'b1, 1'b1, 32'd16);                // byte count above eight
    push_word(rand64(), 4'd9, 1'b1, 1'b1, 32'd9);
    push_word(rand64(), 4'd8, 1'b0, 1'b0, $urandom);          // outside a message
    push_word(rand64(), 4'd3, 1'b0, 1'b1, $urandom);
    push_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd24);           // restarted mid-message
    push_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd16);
    push_word(rand64(), 4'd8, 1'b0, 1'b1, $urandom);
    push_word(rand64(), 4'd3, 1'b1, 1'b0, 32'd11);           // partial word not last
    push_word(rand64(), 4'd8, 1'b0, 1'b1, 32'd0);
    push_word(rand64(), 4'd8, 1'b1, 1'b0, 32'd8);            // zero-byte closing word
    push_word(rand64(), 4'd0, 1'b0, 1'b1, $urandom);
    wait_idle();

    write_seed('0);
    queue_random_words(PHASE_WORDS);
    wait_idle();

    send_idle_pct = 62;
    sink_idle_pct = 16;
    write_seed('1);
    queue_random_words(PHASE_WORDS);
    wait_idle();

    send_idle_pct = 0;
    sink_idle_pct = 0;
    write_seed(rand64());
    queue_random_words(PHASE_WORDS);
    wait_idle();

    if (fail_count == 0) begin
      $display("byte_hash_64 test passed");
    end else begin
      $display("byte_hash_64 test failed");
    end
    $finish;
  end

endmodule
